[hw/rtl/pmct_pkg.sv]
package pmct_pkg;

    // Field widths
    localparam int unsigned MIN_W   = 7;
    localparam int unsigned STEN_W  = 3;
    localparam int unsigned SUNIT_W = 4;
    localparam int unsigned SEG_W   = 7;
    localparam int unsigned REQ_W   = 2;

    // Counting constants
    localparam logic [MIN_W-1:0]   LIMIT_CAP   = 7'd99;
    localparam logic [MIN_W-1:0]   MAX_MIN_RST = 7'd60;
    localparam logic [STEN_W-1:0]  SEC_TENS_TOP  = 3'd5;
    localparam logic [SUNIT_W-1:0] SEC_UNITS_TOP = 4'd9;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_UP    = 2'd1,
        REQ_DOWN  = 2'd2,
        REQ_START = 2'd3
    } t_req;

    typedef logic [SEG_W-1:0] t_seg;

    // Common-cathode segment codes, bit 6 = g ... bit 0 = a
    function automatic t_seg seg_of(input logic [3:0] d);
        t_seg s;
        case (d)
            4'd0: s = 7'h3F;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5B;
            4'd3: s = 7'h4F;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6D;
            4'd6: s = 7'h7D;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7F;
            default: s = 7'h6F;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/pmct_in_if.sv]
interface pmct_in_if;
    logic                       valid;
    logic                       ready;
    logic [pmct_pkg::REQ_W-1:0] req_type;
    logic                       hold;

    modport source (output valid, output req_type, output hold, input ready);
    modport sink   (input valid, input req_type, input hold, output ready);
endinterface

[hw/rtl/pmct_out_if.sv]
interface pmct_out_if;
    logic               valid;
    logic               ready;
    pmct_pkg::t_seg     seg_min_tens;
    pmct_pkg::t_seg     seg_min_units;
    pmct_pkg::t_seg     seg_sec_tens;
    pmct_pkg::t_seg     seg_sec_units;
    logic               running;

    modport source (output valid, output seg_min_tens, output seg_min_units,
                    output seg_sec_tens, output seg_sec_units, output running,
                    input ready);
    modport sink   (input valid, input seg_min_tens, input seg_min_units,
                    input seg_sec_tens, input seg_sec_units, input running,
                    output ready);
endinterface

[hw/rtl/pmct_cfg_if.sv]
interface pmct_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pmct_pkg::MIN_W-1:0] max_minutes;

    modport source (output valid, output max_minutes, input ready);
    modport sink   (input valid, input max_minutes, output ready);
endinterface

[hw/rtl/preset_minute_countdown_timer_unit.sv]
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    req_type[1:0], hold
// o_out     out  valid/ready    seg_min_tens, seg_min_units, seg_sec_tens,
//                               seg_sec_units (7b each), running
// i_cfg     in   valid/ready    max_minutes[6:0]
//
// One request per cycle: the timer state and the display register both load
// at the accept edge, so the result is offered from the next cycle on.
// The output register drains and refills in the same cycle, so a stall only
// blocks input while a result is held and o_out.ready is low.
// Synchronous active-low reset: idle, 00:00, limit 60. Config is always ready.
module preset_minute_countdown_timer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmct_in_if.sink           i_in,
    pmct_out_if.source        o_out,
    pmct_cfg_if.sink          i_cfg
);

    logic [pmct_pkg::MIN_W-1:0]   r_max_min;
    logic [pmct_pkg::MIN_W-1:0]   r_min,   n_min;
    logic [pmct_pkg::STEN_W-1:0]  r_stens, n_stens;
    logic [pmct_pkg::SUNIT_W-1:0] r_sunit, n_sunit;
    logic                         r_act,   n_act;

    logic                         r_out_vld;
    pmct_pkg::t_seg               r_seg_mt, r_seg_mu, r_seg_st, r_seg_su;
    logic                         r_run;

    logic                         accept;
    logic [pmct_pkg::MIN_W-1:0]   lim;
    logic [pmct_pkg::MIN_W-1:0]   min_base;
    logic [14:0]                  prod;
    logic [3:0]                   min_tens;
    logic [3:0]                   min_units;
    logic [7:0]                   tens_x10;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_vld || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;

    // Limit saturates at 99
    assign lim      = (r_max_min > pmct_pkg::LIMIT_CAP) ? pmct_pkg::LIMIT_CAP : r_max_min;
    assign min_base = (r_min > lim) ? '0 : r_min;

    // Next timer state
    always_comb begin
        n_min   = r_min;
        n_stens = r_stens;
        n_sunit = r_sunit;
        n_act   = r_act;
        if (!r_act) begin
            n_min = min_base;
            case (pmct_pkg::t_req'(i_in.req_type))
                pmct_pkg::REQ_UP: begin
                    n_min = (min_base >= lim) ? '0 : min_base + 7'd1;
                end
                pmct_pkg::REQ_DOWN: begin
                    if (min_base != '0) n_min = min_base - 7'd1;
                end
                pmct_pkg::REQ_START: begin
                    if (min_base != '0) begin
                        n_min   = min_base - 7'd1;
                        n_act   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_stens = n_act ? pmct_pkg::SEC_TENS_TOP  : '0;
            n_sunit = n_act ? pmct_pkg::SEC_UNITS_TOP : '0;
        end else if ((pmct_pkg::t_req'(i_in.req_type) == pmct_pkg::REQ_TICK) && !i_in.hold) begin
            if (r_sunit != '0) begin
                n_sunit = r_sunit - 4'd1;
            end else if (r_stens != '0) begin
                n_stens = r_stens - 3'd1;
                n_sunit = pmct_pkg::SEC_UNITS_TOP;
            end else if (r_min != '0) begin
                n_min   = r_min - 7'd1;
                n_stens = pmct_pkg::SEC_TENS_TOP;
                n_sunit = pmct_pkg::SEC_UNITS_TOP;
            end else begin
                n_act   = 1'b0;
                n_min   = '0;
                n_stens = '0;
                n_sunit = '0;
            end
        end
    end

    // Minutes split into digits: x*205 >> 11 is x/10 for x <= 99
    always_comb begin
        prod      = 15'(n_min) * 15'd205;
        min_tens  = prod[14:11];
        tens_x10  = 8'(min_tens) * 8'd10;
        min_units = 4'(8'(n_min) - tens_x10);
    end

    // Config and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_min <= pmct_pkg::MAX_MIN_RST;
            r_min     <= '0;
            r_stens   <= '0;
            r_sunit   <= '0;
            r_act     <= 1'b0;
        end else begin
            if (i_cfg.valid) r_max_min <= i_cfg.max_minutes;
            if (accept) begin
                r_min   <= n_min;
                r_stens <= n_stens;
                r_sunit <= n_sunit;
                r_act   <= n_act;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg_mt <= pmct_pkg::seg_of(min_tens);
            r_seg_mu <= pmct_pkg::seg_of(min_units);
            r_seg_st <= pmct_pkg::seg_of({1'b0, n_stens});
            r_seg_su <= pmct_pkg::seg_of(n_sunit);
            r_run    <= n_act;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.seg_min_tens  = r_seg_mt;
    assign o_out.seg_min_units = r_seg_mu;
    assign o_out.seg_sec_tens  = r_seg_st;
    assign o_out.seg_sec_units = r_seg_su;
    assign o_out.running       = r_run;

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT       = 28;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 30;
    localparam int unsigned N_PHASES       = 8;

    // Segment codes gfedcba per decimal digit
    localparam pmct_pkg::t_seg DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        pmct_pkg::t_req req;
        logic           hold;
    } t_timer_req;

    typedef struct packed {
        pmct_pkg::t_seg min_tens;
        pmct_pkg::t_seg min_units;
        pmct_pkg::t_seg sec_tens;
        pmct_pkg::t_seg sec_units;
        logic           running;
    } t_display;

    logic i_clk;
    logic i_rst_n;

    pmct_in_if  in_if ();
    pmct_out_if out_if ();
    pmct_cfg_if cfg_if ();

    preset_minute_countdown_timer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Requests waiting to be driven, displays waiting to be seen
    t_timer_req  press_q [$];
    t_display    display_q [$];

    // Timer state as predicted
    logic [pmct_pkg::MIN_W-1:0]   lim_reg;
    logic [pmct_pkg::MIN_W-1:0]   tmr_min;
    logic [pmct_pkg::STEN_W-1:0]  tmr_sten;
    logic [pmct_pkg::SUNIT_W-1:0] tmr_sunit;
    logic                         tmr_run;

    int unsigned idle_pct;
    int unsigned holdoff_reqs;
    int unsigned holdoff_seen;
    int unsigned holdoff_left;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned pushed;
    logic        req_taken;

    function automatic pmct_pkg::t_seg digit_seg(input int unsigned d);
        return (d < 10) ? DIGIT_SEG[d] : 7'h6F;
    endfunction

    // Advance the timer by one request and return the display it shows
    function automatic t_display step_timer(input pmct_pkg::t_req req, input logic hold);
        logic [pmct_pkg::MIN_W-1:0] cap;
        t_display                   disp;
        cap = (lim_reg > pmct_pkg::LIMIT_CAP) ? pmct_pkg::LIMIT_CAP : lim_reg;
        if (!tmr_run) begin
            // a lowered limit clears minutes above it first
            if (tmr_min > cap) tmr_min = '0;
            case (req)
                pmct_pkg::REQ_UP: begin
                    tmr_min = (tmr_min >= cap) ? '0 : tmr_min + 7'd1;
                end
                pmct_pkg::REQ_DOWN: begin
                    if (tmr_min != '0) tmr_min = tmr_min - 7'd1;
                end
                pmct_pkg::REQ_START: begin
                    if (tmr_min != '0) begin
                        tmr_min   = tmr_min - 7'd1;
                        tmr_sten  = pmct_pkg::SEC_TENS_TOP;
                        tmr_sunit = pmct_pkg::SEC_UNITS_TOP;
                        tmr_run   = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!tmr_run) begin
                tmr_sten  = '0;
                tmr_sunit = '0;
            end
        end else if (req == pmct_pkg::REQ_TICK && !hold) begin
            if (tmr_sunit != '0) begin
                tmr_sunit = tmr_sunit - 4'd1;
            end else if (tmr_sten != '0) begin
                tmr_sten  = tmr_sten - 3'd1;
                tmr_sunit = pmct_pkg::SEC_UNITS_TOP;
            end else if (tmr_min != '0) begin
                tmr_min   = tmr_min - 7'd1;
                tmr_sten  = pmct_pkg::SEC_TENS_TOP;
                tmr_sunit = pmct_pkg::SEC_UNITS_TOP;
            end else begin
                tmr_run   = 1'b0;
                tmr_min   = '0;
                tmr_sten  = '0;
                tmr_sunit = '0;
            end
        end
        disp.min_tens  = digit_seg(tmr_min / 10);
        disp.min_units = digit_seg(tmr_min % 10);
        disp.sec_tens  = digit_seg(tmr_sten);
        disp.sec_units = digit_seg(tmr_sunit);
        disp.running   = tmr_run;
        return disp;
    endfunction

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Accept edge: predict on requests, track the limit, check displays
    always @(posedge i_clk) begin : monitor
        t_display want;
        logic     busy;
        req_taken = 1'b0;
        if (i_rst_n) begin
            busy = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                lim_reg = cfg_if.max_minutes;
                busy    = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                display_q.push_back(step_timer(pmct_pkg::t_req'(in_if.req_type),
                                               in_if.hold));
                req_taken = 1'b1;
                busy      = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                busy = 1'b1;
                if (display_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: display with none expected, actual %h %h %h %h %b",
                             $time, out_if.seg_min_tens, out_if.seg_min_units,
                             out_if.seg_sec_tens, out_if.seg_sec_units, out_if.running);
                end else begin
                    want = display_q.pop_front();
                    check_field("seg_min_tens",  want.min_tens,  out_if.seg_min_tens);
                    check_field("seg_min_units", want.min_units, out_if.seg_min_units);
                    check_field("seg_sec_tens",  want.sec_tens,  out_if.seg_sec_tens);
                    check_field("seg_sec_units", want.sec_units, out_if.seg_sec_units);
                    check_field("running", 7'(want.running), 7'(out_if.running));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Request driver: a presented request stays on the bus until taken
    always @(negedge i_clk) begin : req_drive
        logic offer;
        if (req_taken) void'(press_q.pop_front());
        if (!i_rst_n)
            offer = 1'b0;
        else if (in_if.valid && !req_taken)
            offer = 1'b1;
        else
            offer = (press_q.size() > 0) && ($urandom_range(99) >= idle_pct);
        if (offer) begin
            in_if.req_type <= press_q[0].req;
            in_if.hold     <= press_q[0].hold;
        end
        in_if.valid <= offer;
    end

    // Display receiver: random stalls plus requested long hold-offs
    always @(negedge i_clk) begin : disp_drive
        if (holdoff_seen != holdoff_reqs) begin
            holdoff_seen = holdoff_reqs;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic push_req(input pmct_pkg::t_req req, input logic hold);
        press_q.push_back('{req: req, hold: hold});
        pushed++;
    endtask

    // Sender pauses here until every display has come back
    task automatic wait_drained();
        while (press_q.size() != 0 || display_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [pmct_pkg::MIN_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.max_minutes <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Set some minutes, start, then mostly ticks with a little noise
    task automatic add_session();
        int unsigned n;
        n = $urandom_range(0, 3);
        repeat (n) push_req(pmct_pkg::REQ_UP, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0) push_req(pmct_pkg::REQ_DOWN, 1'($urandom_range(1)));
        push_req(pmct_pkg::REQ_START, 1'($urandom_range(1)));
        n = $urandom_range(1, 80);
        repeat (n) begin
            if ($urandom_range(9) == 0)
                push_req(pmct_pkg::t_req'($urandom_range(3)), 1'($urandom_range(1)));
            else
                push_req(pmct_pkg::REQ_TICK, 1'($urandom_range(9) == 0));
        end
    endtask

    // Push a train of plain ticks, then up presses to step minutes through the whole range, then a few downs
    task automatic add_up_burst();
        repeat (250) push_req(pmct_pkg::REQ_TICK, 1'b0);
        repeat ($urandom_range(98, 101)) push_req(pmct_pkg::REQ_UP, 1'($urandom_range(1)));
        repeat ($urandom_range(1, 3)) push_req(pmct_pkg::REQ_DOWN, 1'($urandom_range(1)));
    endtask

    initial begin : stimulus
        logic [pmct_pkg::MIN_W-1:0] plan [N_PHASES];
        plan = '{7'd60, 7'd99, 7'd1, 7'd127, 7'd0, 7'd2, 7'd7, 7'd60};

        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.req_type     = pmct_pkg::REQ_TICK;
        in_if.hold         = 1'b0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.max_minutes = pmct_pkg::MAX_MIN_RST;
        idle_pct           = IDLE_PCT;
        holdoff_reqs       = 0;
        holdoff_seen       = 0;
        holdoff_left       = 0;
        quiet_cycles       = 0;
        mismatches         = 0;
        pushed             = 0;
        req_taken          = 1'b0;
        lim_reg            = pmct_pkg::MAX_MIN_RST;
        tmr_min            = '0;
        tmr_sten           = '0;
        tmr_sunit          = '0;
        tmr_run            = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle behavior at the reset limit: tick, hold, start at zero, down at zero, then up and down presses
        push_req(pmct_pkg::REQ_TICK, 1'b0);
        push_req(pmct_pkg::REQ_TICK, 1'b1);
        push_req(pmct_pkg::REQ_START, 1'b0);
        push_req(pmct_pkg::REQ_DOWN, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b1);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_DOWN, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        wait_drained();

        // Limit lowered below the set minutes, then wrap at the top
        write_limit(7'd1);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        wait_drained();

        // Zero limit: every up press wraps
        write_limit(7'd0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b1);
        wait_drained();

        // Start, buttons ignored while running, hold, one tick
        write_limit(7'd99);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_START, 1'b0);
        push_req(pmct_pkg::REQ_UP, 1'b0);
        push_req(pmct_pkg::REQ_DOWN, 1'b1);
        push_req(pmct_pkg::REQ_START, 1'b1);
        push_req(pmct_pkg::REQ_TICK, 1'b1);
        push_req(pmct_pkg::REQ_TICK, 1'b0);
        wait_drained();

        // Random phases, each under its own limit
        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(plan[p]);
            idle_pct = (p == 3) ? 0 : IDLE_PCT;
            pushed   = 0;
            while (pushed < PHASE_ITEMS) add_session();
            if (plan[p] >= pmct_pkg::LIMIT_CAP) add_up_burst();
            // long receiver stall while requests keep coming
            if (p == 1 || p == 6) holdoff_reqs++;
            wait_drained();
        end

        idle_pct = IDLE_PCT;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
